[hdl/leadscrew_compensation_interpolator_core_macros.svh]
// Assertion macros shared by the RTL files.
`ifndef LEADSCREW_COMPENSATION_INTERPOLATOR_CORE_MACROS_SVH
`define LEADSCREW_COMPENSATION_INTERPOLATOR_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define LCI_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lci assertion failed");
`define LCI_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lci assertion failed");
`else
`define LCI_ASSERT_NOW(label, ante, cons)
`define LCI_ASSERT_NEXT(label, ante, cons)
`endif
`endif

[hdl/lci_pkg.sv]
package lci_pkg;
	localparam int TABLE_DEPTH = 256;
	localparam int TBL_AW = $clog2(TABLE_DEPTH);
	localparam int CNT_W = 9;
	localparam int DW = 32;
	localparam int DIV_STEPS = 2 * DW;
	localparam int DIV_CW = $clog2(DIV_STEPS);

	localparam logic [1:0] CMD_WRITE = 2'd0;
	localparam logic [1:0] CMD_M2A_POS = 2'd1;
	localparam logic [1:0] CMD_M2A_NEG = 2'd2;
	localparam logic [1:0] CMD_A2M = 2'd3;

	localparam logic REG_ENABLE = 1'b0;
	localparam logic REG_COUNT = 1'b1;

	typedef enum logic [1:0] {
		COL_MACHINE,
		COL_POS,
		COL_NEG
	} col_sel_t;

	typedef struct packed {
		logic start;
		logic [DW-1:0] a;
		logic [DW-1:0] b;
		logic [DW-1:0] c;
	} div_req_t;

	typedef struct packed {
		logic done;
		logic [DW-1:0] quotient;
		logic fault;
	} div_rsp_t;
endpackage

[hdl/lci_table.sv]
module lci_table import lci_pkg::*; (
	input logic clk,
	input logic wr_en,
	input logic [TBL_AW-1:0] wr_addr,
	input logic [DW-1:0] wr_machine,
	input logic [DW-1:0] wr_pos,
	input logic [DW-1:0] wr_neg,
	input logic [TBL_AW-1:0] rd_addr,
	output logic [DW-1:0] rd_machine,
	output logic [DW-1:0] rd_pos,
	output logic [DW-1:0] rd_neg
);
	logic [DW-1:0] machine_mem [TABLE_DEPTH];
	logic [DW-1:0] pos_mem [TABLE_DEPTH];
	logic [DW-1:0] neg_mem [TABLE_DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			machine_mem[wr_addr] <= wr_machine;
			pos_mem[wr_addr] <= wr_pos;
			neg_mem[wr_addr] <= wr_neg;
		end
		rd_machine <= machine_mem[rd_addr];
		rd_pos <= pos_mem[rd_addr];
		rd_neg <= neg_mem[rd_addr];
	end
endmodule

[hdl/lci_divider.sv]
`include "leadscrew_compensation_interpolator_core_macros.svh"
module lci_divider import lci_pkg::*; (
	input logic clk,
	input logic arst_n,
	input div_req_t req,
	output div_rsp_t rsp
);
	typedef enum logic [3:0] {
		DV_IDLE = 4'b0001,
		DV_MUL = 4'b0010,
		DV_DIV = 4'b0100,
		DV_FIN = 4'b1000
	} dv_state_t;

	dv_state_t state_q;
	logic [DW-1:0] ma_q, mb_q, mc_q, rem_q;
	logic neg_q;
	logic [2*DW-1:0] num_q, prod;
	logic [DIV_CW-1:0] cnt_q;
	div_rsp_t rsp_q;
	logic [DW:0] rem_sh;
	logic qbit;
	logic [DW:0] rem_diff;
	logic ovf;

	assign prod = (2*DW)'(ma_q) * (2*DW)'(mb_q);
	assign rem_sh = {rem_q, num_q[2*DW-1]};
	assign rem_diff = rem_sh - {1'b0, mc_q};
	assign qbit = !rem_diff[DW];
	assign ovf = neg_q ? (num_q > {{DW{1'b0}}, 1'b1, {(DW-1){1'b0}}})
		: (num_q > {{(DW+1){1'b0}}, {(DW-1){1'b1}}});
	assign rsp = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= DV_IDLE;
			rsp_q <= '0;
			ma_q <= '0;
			mb_q <= '0;
			mc_q <= '0;
			rem_q <= '0;
			neg_q <= 1'b0;
			num_q <= '0;
			cnt_q <= '0;
		end else begin
			case (state_q)
				DV_IDLE: begin
					if (req.start && req.c == '0) begin
						rsp_q <= '{done: 1'b1, quotient: '1, fault: 1'b1};
					end else begin
						rsp_q.done <= 1'b0;
					end
					if (req.start && req.c != '0) begin
						ma_q <= req.a[DW-1] ? -req.a : req.a;
						mb_q <= req.b[DW-1] ? -req.b : req.b;
						mc_q <= req.c[DW-1] ? -req.c : req.c;
						neg_q <= req.a[DW-1] ^ req.b[DW-1] ^ req.c[DW-1];
						state_q <= DV_MUL;
					end
				end
				DV_MUL: begin
					rsp_q.done <= 1'b0;
					num_q <= prod + {{(DW+1){1'b0}}, mc_q[DW-1:1]};
					rem_q <= '0;
					cnt_q <= '0;
					state_q <= DV_DIV;
				end
				DV_DIV: begin
					rsp_q.done <= 1'b0;
					rem_q <= qbit ? rem_diff[DW-1:0] : rem_sh[DW-1:0];
					num_q <= {num_q[2*DW-2:0], qbit};
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == DIV_CW'(DIV_STEPS - 1)) begin
						state_q <= DV_FIN;
					end
				end
				DV_FIN: begin
					if (ovf) begin
						rsp_q <= '{done: 1'b1, quotient: '1, fault: 1'b1};
					end else begin
						rsp_q <= '{done: 1'b1,
							quotient: neg_q ? -num_q[DW-1:0] : num_q[DW-1:0],
							fault: 1'b0};
					end
					state_q <= DV_IDLE;
				end
				default: begin
					rsp_q.done <= 1'b0;
					state_q <= DV_IDLE;
				end
			endcase
		end
	end

	`LCI_ASSERT_NEXT(a_div_done_pulse, rsp_q.done, !rsp_q.done)
endmodule

[hdl/leadscrew_compensation_interpolator_core.sv]
// Leadscrew pitch-error compensation: a 256-entry calibration table of machine,
// positive-approach and negative-approach positions, and a lookup that
// binary-searches one column and interpolates linearly. A query with
// compensation off or fewer than two entries returns its input unchanged. A
// compensated query's time is set by the search loop over the one table read
// port and by the divider, which produces one quotient bit per cycle. The
// table is not cleared at reset: read only written entries.
`include "leadscrew_compensation_interpolator_core_macros.svh"
module leadscrew_compensation_interpolator_core import lci_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [2:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	input logic in_valid,
	output logic in_ready,
	input logic [1:0] command,
	input logic [7:0] entry_index,
	input logic signed [31:0] machine_value,
	input logic signed [31:0] actual_value,
	input logic signed [31:0] actual_neg_value,
	input logic signed [31:0] current_value,
	output logic out_valid,
	input logic out_ready,
	output logic signed [31:0] result_value,
	output logic divide_fault
);
	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_SEARCH = 7'b0000010,
		ST_CMP = 7'b0000100,
		ST_LO = 7'b0001000,
		ST_HI = 7'b0010000,
		ST_DIV = 7'b0100000,
		ST_FINISH = 7'b1000000
	} state_t;

	state_t state_q;
	logic enable_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] n_eff;
	logic active;
	logic accept, wr_en, cfg_wr;
	logic [DW-1:0] query_q, key_lo_q, val_lo_q, result_q;
	logic fault_q;
	col_sel_t key_col_q, val_col_q, key_col_d, val_col_d;
	logic [TBL_AW-1:0] lo_q, hi_q, mid, span, rd_addr;
	logic [TBL_AW:0] mid_sum;
	logic [DW-1:0] rd_machine, rd_pos, rd_neg, rd_key, rd_val;
	logic out_valid_q, out_free;
	logic [DW-1:0] result_value_q;
	logic divide_fault_q;
	div_req_t div_req;
	div_rsp_t div_rsp;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign prdata = (paddr[2] == REG_COUNT) ? {{(32-CNT_W){1'b0}}, count_q}
		: {31'b0, enable_q};

	assign n_eff = (32'(count_q) > TABLE_DEPTH) ? CNT_W'(TABLE_DEPTH) : count_q;
	assign active = enable_q && (n_eff >= CNT_W'(2));
	assign in_ready = (state_q == ST_IDLE);
	assign accept = in_valid && in_ready;
	assign wr_en = accept && (command == CMD_WRITE) && (32'(entry_index) < TABLE_DEPTH);

	always_comb begin
		case (command)
			CMD_M2A_POS: begin
				key_col_d = COL_MACHINE;
				val_col_d = COL_POS;
			end
			CMD_M2A_NEG: begin
				key_col_d = COL_MACHINE;
				val_col_d = COL_NEG;
			end
			default: begin
				key_col_d = (actual_value <= current_value) ? COL_POS : COL_NEG;
				val_col_d = COL_MACHINE;
			end
		endcase
	end

	assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid = mid_sum[TBL_AW:1];
	assign span = hi_q - lo_q;

	always_comb begin
		case (state_q)
			ST_SEARCH: rd_addr = (span > TBL_AW'(1)) ? mid : lo_q;
			default: rd_addr = hi_q;
		endcase
	end

	always_comb begin
		case (key_col_q)
			COL_POS: rd_key = rd_pos;
			COL_NEG: rd_key = rd_neg;
			default: rd_key = rd_machine;
		endcase
		case (val_col_q)
			COL_POS: rd_val = rd_pos;
			COL_NEG: rd_val = rd_neg;
			default: rd_val = rd_machine;
		endcase
	end

	assign div_req.start = (state_q == ST_HI);
	assign div_req.a = query_q - key_lo_q;
	assign div_req.b = rd_val - val_lo_q;
	assign div_req.c = rd_key - key_lo_q;

	lci_table u_table (
		.clk(clk),
		.wr_en(wr_en),
		.wr_addr(TBL_AW'(entry_index)),
		.wr_machine(machine_value),
		.wr_pos(actual_value),
		.wr_neg(actual_neg_value),
		.rd_addr(rd_addr),
		.rd_machine(rd_machine),
		.rd_pos(rd_pos),
		.rd_neg(rd_neg)
	);

	lci_divider u_divider (
		.clk(clk),
		.arst_n(arst_n),
		.req(div_req),
		.rsp(div_rsp)
	);

	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
			count_q <= '0;
		end else if (cfg_wr) begin
			if (paddr[2] == REG_ENABLE) begin
				enable_q <= pwdata[0];
			end else begin
				count_q <= pwdata[CNT_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
			query_q <= '0;
			key_lo_q <= '0;
			val_lo_q <= '0;
			result_q <= '0;
			fault_q <= 1'b0;
			key_col_q <= COL_MACHINE;
			val_col_q <= COL_MACHINE;
			lo_q <= '0;
			hi_q <= '0;
			result_value_q <= '0;
			divide_fault_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && state_q != ST_FINISH) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept && command != CMD_WRITE) begin
						query_q <= (command == CMD_A2M) ? actual_value : machine_value;
						result_q <= (command == CMD_A2M) ? actual_value : machine_value;
						fault_q <= 1'b0;
						key_col_q <= key_col_d;
						val_col_q <= val_col_d;
						lo_q <= '0;
						hi_q <= TBL_AW'(n_eff - 1'b1);
						state_q <= active ? ST_SEARCH : ST_FINISH;
					end
				end
				ST_SEARCH: begin
					state_q <= (span > TBL_AW'(1)) ? ST_CMP : ST_LO;
				end
				ST_CMP: begin
					if ($signed(rd_key) > $signed(query_q)) begin
						hi_q <= mid;
					end else begin
						lo_q <= mid;
					end
					state_q <= ST_SEARCH;
				end
				ST_LO: begin
					key_lo_q <= rd_key;
					val_lo_q <= rd_val;
					state_q <= ST_HI;
				end
				ST_HI: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_rsp.done) begin
						result_q <= div_rsp.quotient + val_lo_q;
						fault_q <= div_rsp.fault;
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						result_value_q <= result_q;
						divide_fault_q <= fault_q;
						out_valid_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign result_value = result_value_q;
	assign divide_fault = divide_fault_q;

	`LCI_ASSERT_NOW(a_cmp_span, state_q == ST_CMP, span > TBL_AW'(1))
	`LCI_ASSERT_NOW(a_div_in_wait, div_rsp.done, state_q == ST_DIV)
	`LCI_ASSERT_NEXT(a_write_no_work, accept && command == CMD_WRITE, state_q == ST_IDLE)
	`LCI_ASSERT_NEXT(a_finish_loads, state_q == ST_FINISH && out_free, out_valid_q)
endmodule
